// File: hw/rtl/bvd_pkg.sv
// ----------------------------------------------------------------------------
// bvd_pkg
// Types and constants shared by the bulk varint decoder modules.
// ----------------------------------------------------------------------------
package bvd_pkg;

    localparam int BYTE_W    = 8;
    localparam int GROUP_W   = 7;
    localparam int MORE_BIT  = 7;
    localparam int VALID_W   = 4;
    localparam int VALUE_W   = 64;
    localparam int NARROW_W  = 32;
    localparam int SHIFT_W   = 7;
    localparam int SHIFT_MAX = 64;
    localparam int CFG_IDX_W = 8;
    localparam int OUT_W     = ((VALUE_W + VALID_W + 7) / 8) * 8;

    typedef logic [BYTE_W-1:0]    t_byte;
    typedef logic [GROUP_W-1:0]   t_group;
    typedef logic [VALUE_W-1:0]   t_value;
    typedef logic [SHIFT_W-1:0]   t_shift;
    typedef logic [VALID_W-1:0]   t_valid_cnt;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_NARROW_MODE = t_cfg_idx'(0);
    localparam t_cfg_idx REG_VALUE_COUNT = t_cfg_idx'(1);

endpackage

// File: hw/rtl/bvd_lane.sv
// ----------------------------------------------------------------------------
// bvd_lane
// Gathers the 7-bit groups of the varint segment that ends at one byte lane.
// ----------------------------------------------------------------------------
module bvd_lane #(
    parameter int BYTES_PER_ITEM = 8,
    parameter int LANE           = 0,
    parameter int SID_W          = 4
) (
    input  bvd_pkg::t_group i_group [BYTES_PER_ITEM],
    input  bvd_pkg::t_shift i_pos   [BYTES_PER_ITEM],
    input  logic [SID_W-1:0] i_sid  [BYTES_PER_ITEM],
    output bvd_pkg::t_value o_val
);
    import bvd_pkg::*;

    always_comb begin
        o_val = '0;
        for (int k = 0; k <= LANE; k++) begin
            if (i_sid[k] == i_sid[LANE]) begin
                o_val = o_val | (t_value'(i_group[k]) << i_pos[k]);
            end
        end
    end

endmodule

// File: hw/rtl/bvd_front.sv
// ----------------------------------------------------------------------------
// bvd_front
// Finds terminating bytes and segment positions, runs the lanes and
// registers their results for the merge stage.
// ----------------------------------------------------------------------------
module bvd_front #(
    parameter int BYTES_PER_ITEM = 8,
    parameter int SID_W          = 4
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  bvd_pkg::t_byte          i_bytes [BYTES_PER_ITEM],
    input  bvd_pkg::t_valid_cnt     i_bytes_valid,
    input  logic                    i_take,
    output logic                    o_valid,
    output bvd_pkg::t_value         o_lane_val [BYTES_PER_ITEM],
    output logic [BYTES_PER_ITEM-1:0] o_term,
    output logic [BYTES_PER_ITEM-1:0] o_first,
    output logic [SID_W-1:0]        o_sid [BYTES_PER_ITEM],
    output logic [SID_W-1:0]        o_nterm,
    output bvd_pkg::t_value         o_tail_val,
    output bvd_pkg::t_shift         o_tail_sh
);
    import bvd_pkg::*;

    t_valid_cnt              nv;
    t_group                  group [BYTES_PER_ITEM];
    t_shift                  pos   [BYTES_PER_ITEM];
    logic [SID_W-1:0]        sid   [BYTES_PER_ITEM];
    logic [BYTES_PER_ITEM-1:0] term;
    logic [SID_W-1:0]        cnt;
    t_shift                  run_pos;
    t_value                  lane_val [BYTES_PER_ITEM];
    t_value                  tail_val;
    t_shift                  tail_sh;

    logic                    r_valid;
    t_value                  r_lane_val [BYTES_PER_ITEM];
    logic [BYTES_PER_ITEM-1:0] r_term;
    logic [BYTES_PER_ITEM-1:0] r_first;
    logic [SID_W-1:0]        r_sid [BYTES_PER_ITEM];
    logic [SID_W-1:0]        r_nterm;
    t_value                  r_tail_val;
    t_shift                  r_tail_sh;

    always_comb begin
        if (32'(i_bytes_valid) > BYTES_PER_ITEM) begin
            nv = t_valid_cnt'(BYTES_PER_ITEM);
        end else begin
            nv = i_bytes_valid;
        end
        run_pos = '0;
        cnt     = '0;
        for (int k = 0; k < BYTES_PER_ITEM; k++) begin
            group[k] = i_bytes[k][GROUP_W-1:0];
            term[k]  = (k < 32'(nv)) && !i_bytes[k][MORE_BIT];
            pos[k]   = run_pos;
            sid[k]   = cnt;
            if (term[k]) begin
                run_pos = '0;
                cnt     = cnt + SID_W'(1);
            end else begin
                run_pos = run_pos + t_shift'(GROUP_W);
            end
        end
    end

    for (genvar g = 0; g < BYTES_PER_ITEM; g++) begin : g_lane
        bvd_lane #(
            .BYTES_PER_ITEM (BYTES_PER_ITEM),
            .LANE           (g),
            .SID_W          (SID_W)
        ) u_lane (
            .i_group (group),
            .i_pos   (pos),
            .i_sid   (sid),
            .o_val   (lane_val[g])
        );
    end

    always_comb begin
        tail_val = '0;
        tail_sh  = '0;
        for (int k = 0; k < BYTES_PER_ITEM; k++) begin
            if ((k + 1 == 32'(nv)) && !term[k]) begin
                tail_val = lane_val[k];
                tail_sh  = pos[k] + t_shift'(GROUP_W);
            end
        end
    end

    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_lane_val <= lane_val;
            r_term     <= term;
            r_first    <= term & ~(term - BYTES_PER_ITEM'(1));
            r_sid      <= sid;
            r_nterm    <= cnt;
            r_tail_val <= tail_val;
            r_tail_sh  <= tail_sh;
        end
    end

    assign o_valid    = r_valid;
    assign o_lane_val = r_lane_val;
    assign o_term     = r_term;
    assign o_first    = r_first;
    assign o_sid      = r_sid;
    assign o_nterm    = r_nterm;
    assign o_tail_val = r_tail_val;
    assign o_tail_sh  = r_tail_sh;

endmodule

// File: hw/rtl/bvd_merge.sv
// ----------------------------------------------------------------------------
// bvd_merge
// Joins lane results with the carried partial varint, keeps the run count
// and presents the completed values one transfer at a time.
// ----------------------------------------------------------------------------
module bvd_merge #(
    parameter int BYTES_PER_ITEM = 8,
    parameter int COUNT_BITS     = 24,
    parameter int SID_W          = 4
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    input  bvd_pkg::t_cfg_idx       i_cfg_index,
    input  logic [COUNT_BITS-1:0]   i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_take,
    input  bvd_pkg::t_value         i_lane_val [BYTES_PER_ITEM],
    input  logic [BYTES_PER_ITEM-1:0] i_term,
    input  logic [BYTES_PER_ITEM-1:0] i_first,
    input  logic [SID_W-1:0]        i_sid [BYTES_PER_ITEM],
    input  logic [SID_W-1:0]        i_nterm,
    input  bvd_pkg::t_value         i_tail_val,
    input  bvd_pkg::t_shift         i_tail_sh,
    output logic                    o_valid,
    input  logic                    i_ready,
    output bvd_pkg::t_value         o_value,
    output bvd_pkg::t_valid_cnt     o_bytes_used,
    output logic                    o_last,
    output logic                    o_done
);
    import bvd_pkg::*;

    localparam int IDX_W = (BYTES_PER_ITEM > 1) ? $clog2(BYTES_PER_ITEM) : 1;

    logic                      r_narrow;
    t_value                    r_partial;
    t_shift                    r_shift;
    logic [COUNT_BITS-1:0]     r_left;
    logic                      r_finished;
    logic [BYTES_PER_ITEM-1:0] r_pend;
    logic [BYTES_PER_ITEM-1:0] r_done;
    t_value                    r_val [BYTES_PER_ITEM];

    t_value                    n_partial;
    t_shift                    n_shift;
    logic [COUNT_BITS-1:0]     n_left;
    logic                      n_finished;
    logic [BYTES_PER_ITEM-1:0] n_pend;

    logic [BYTES_PER_ITEM-1:0] emit;
    logic [BYTES_PER_ITEM-1:0] done;
    t_value                    val [BYTES_PER_ITEM];
    logic [COUNT_BITS-1:0]     nterm;
    logic [SHIFT_W:0]          sum_sh;
    logic                      active;
    logic                      finish;
    logic                      single;
    logic                      xfer;
    logic                      free;
    logic                      found;
    logic [IDX_W-1:0]          sel;

    always_comb begin
        nterm = COUNT_BITS'(i_nterm);
        for (int j = 0; j < BYTES_PER_ITEM; j++) begin
            emit[j] = i_term[j] && (COUNT_BITS'(i_sid[j]) < r_left);
            done[j] = i_term[j] && (COUNT_BITS'(i_sid[j]) + COUNT_BITS'(1) == r_left);
            if (i_first[j]) begin
                val[j] = r_partial | (i_lane_val[j] << r_shift);
            end else begin
                val[j] = i_lane_val[j];
            end
            if (r_narrow) begin
                val[j][VALUE_W-1:NARROW_W] = '0;
            end
        end
    end

    always_comb begin
        found = 1'b0;
        sel   = '0;
        for (int j = 0; j < BYTES_PER_ITEM; j++) begin
            if (r_pend[j] && !found) begin
                sel   = IDX_W'(j);
                found = 1'b1;
            end
        end
    end

    assign o_valid      = |r_pend;
    assign o_value      = r_val[sel];
    assign o_bytes_used = t_valid_cnt'(32'(sel) + 1);
    assign single       = (r_pend & (r_pend - BYTES_PER_ITEM'(1))) == '0;
    assign o_last       = single;
    assign o_done       = r_done[sel];
    assign xfer         = o_valid && i_ready;
    assign free         = !o_valid || (single && xfer);
    assign o_take       = i_valid && free;
    assign active       = o_take && !r_finished;
    assign finish       = r_left <= nterm;
    assign sum_sh       = {1'b0, r_shift} + {1'b0, i_tail_sh};

    always_comb begin
        n_partial  = r_partial;
        n_shift    = r_shift;
        n_left     = r_left;
        n_finished = r_finished;
        if (active) begin
            if (finish) begin
                n_partial  = '0;
                n_shift    = '0;
                n_left     = '0;
                n_finished = 1'b1;
            end else begin
                n_left = r_left - nterm;
                if (i_nterm != '0) begin
                    n_partial = i_tail_val;
                    n_shift   = (i_tail_sh > t_shift'(SHIFT_MAX)) ? t_shift'(SHIFT_MAX)
                                                                 : i_tail_sh;
                end else begin
                    n_partial = r_partial | (i_tail_val << r_shift);
                    n_shift   = (sum_sh > (SHIFT_W+1)'(SHIFT_MAX)) ? t_shift'(SHIFT_MAX)
                                                                  : sum_sh[SHIFT_W-1:0];
                end
            end
        end
        if (free) begin
            n_pend = active ? emit : '0;
        end else if (xfer) begin
            n_pend = r_pend & ~(BYTES_PER_ITEM'(1) << sel);
        end else begin
            n_pend = r_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_narrow   <= 1'b0;
            r_partial  <= '0;
            r_shift    <= '0;
            r_left     <= '0;
            r_finished <= 1'b1;
            r_pend     <= '0;
        end else begin
            r_pend <= n_pend;
            if (i_cfg_valid && (i_cfg_index == REG_NARROW_MODE)) begin
                r_narrow <= i_cfg_data[0];
            end
            if (i_cfg_valid && (i_cfg_index == REG_VALUE_COUNT)) begin
                r_partial  <= '0;
                r_shift    <= '0;
                r_left     <= i_cfg_data;
                r_finished <= (i_cfg_data == '0);
            end else begin
                r_partial  <= n_partial;
                r_shift    <= n_shift;
                r_left     <= n_left;
                r_finished <= n_finished;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (free && active) begin
            r_val  <= val;
            r_done <= done;
        end
    end

endmodule

// File: hw/rtl/bulk_varint_decoder.sv
// ----------------------------------------------------------------------------
// bulk_varint_decoder
// Unsigned LEB128 varint decoder for runs of bytes, several bytes a transfer.
// An item's values pass through the front registers and then the merge registers before they transfer.
// Throughput: one value per cycle while m_axis_tready is high; the next item is taken
// as the last value of the item before it transfers; the output port carries one value.
// Reset: synchronous active-low; no run is active until value_count is written.
// ----------------------------------------------------------------------------
module bulk_varint_decoder #(
    parameter int BYTES_PER_ITEM = 8,
    parameter int COUNT_BITS     = 24
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // byte_0 .. byte_(BYTES_PER_ITEM-1), bytes_valid, zero fill
    input  logic [((8*BYTES_PER_ITEM+bvd_pkg::VALID_W+7)/8)*8-1:0] s_axis_tdata,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // value, bytes_used, zero fill
    output logic [bvd_pkg::OUT_W-1:0] m_axis_tdata,
    output logic                    m_axis_tlast,
    // run_done
    output logic                    m_axis_tuser,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  bvd_pkg::t_cfg_idx       i_cfg_index,
    input  logic [COUNT_BITS-1:0]   i_cfg_data
);
    import bvd_pkg::*;

    localparam int SID_W  = $clog2(BYTES_PER_ITEM + 1);
    localparam int BYTE_BITS = BYTE_W * BYTES_PER_ITEM;

    t_byte                     in_bytes [BYTES_PER_ITEM];
    t_valid_cnt                in_valid_cnt;
    logic                      f_valid;
    logic                      m_take;
    t_value                    f_lane_val [BYTES_PER_ITEM];
    logic [BYTES_PER_ITEM-1:0] f_term;
    logic [BYTES_PER_ITEM-1:0] f_first;
    logic [SID_W-1:0]          f_sid [BYTES_PER_ITEM];
    logic [SID_W-1:0]          f_nterm;
    t_value                    f_tail_val;
    t_shift                    f_tail_sh;
    t_value                    out_value;
    t_valid_cnt                out_used;

    for (genvar g = 0; g < BYTES_PER_ITEM; g++) begin : g_unpack
        assign in_bytes[g] = s_axis_tdata[g*BYTE_W +: BYTE_W];
    end
    assign in_valid_cnt = s_axis_tdata[BYTE_BITS +: VALID_W];

    assign o_cfg_ready = 1'b1;

    bvd_front #(
        .BYTES_PER_ITEM (BYTES_PER_ITEM),
        .SID_W          (SID_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_bytes       (in_bytes),
        .i_bytes_valid (in_valid_cnt),
        .i_take        (m_take),
        .o_valid       (f_valid),
        .o_lane_val    (f_lane_val),
        .o_term        (f_term),
        .o_first       (f_first),
        .o_sid         (f_sid),
        .o_nterm       (f_nterm),
        .o_tail_val    (f_tail_val),
        .o_tail_sh     (f_tail_sh)
    );

    bvd_merge #(
        .BYTES_PER_ITEM (BYTES_PER_ITEM),
        .COUNT_BITS     (COUNT_BITS),
        .SID_W          (SID_W)
    ) u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (f_valid),
        .o_take       (m_take),
        .i_lane_val   (f_lane_val),
        .i_term       (f_term),
        .i_first      (f_first),
        .i_sid        (f_sid),
        .i_nterm      (f_nterm),
        .i_tail_val   (f_tail_val),
        .i_tail_sh    (f_tail_sh),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_value      (out_value),
        .o_bytes_used (out_used),
        .o_last       (m_axis_tlast),
        .o_done       (m_axis_tuser)
    );

    assign m_axis_tdata = {{(OUT_W-VALUE_W-VALID_W){1'b0}}, out_used, out_value};

endmodule
